// ----- design/hpr_pkg.sv -----
// hpr_pkg: shared types and constants of the hid report pdu reassembler
// no dependencies

package hpr_pkg;

	localparam int PDU_BYTES_DEF  = 48;
	localparam int REPORT_PAYLOAD = 6;
	localparam int BYTE_W         = 8;
	localparam int IDX_W          = 6;
	localparam int CFG_IDX_W      = 2;
	localparam int IN_DATA_W      = 64;
	localparam int OUT_DATA_W     = 24;

	localparam logic [7:0] TAG_RESET   = 8'h03;
	localparam logic [7:0] START_RESET = 8'hFF;
	localparam logic [7:0] SIZE_MASK   = 8'h3F;
	localparam logic [7:0] MAX_SIZE    = 8'd6;

	localparam logic [CFG_IDX_W-1:0] REG_TAG   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START = 2'd1;

	typedef enum logic [1:0] {
		STAT_PENDING  = 2'd0,
		STAT_COMPLETE = 2'd1,
		STAT_BAD_TAG  = 2'd2,
		STAT_BAD_PDU  = 2'd3
	} status_t;

	typedef struct packed {
		status_t           status;
		logic              ack_seen;
		logic [BYTE_W-1:0] pdu_byte;
		logic [IDX_W-1:0]  byte_index;
		logic              last;
	} res_t;

endpackage

// ----- design/hid_report_pdu_reassembler_top.sv -----
// hid_report_pdu_reassembler_top: reassembles a pdu from 8-byte hid reports
// depends on hpr_pkg, hpr_ram, hpr_shift, hpr_out
//
// flow: a rejected or pending report goes to the result state, then into the
//   output register; an appending report first writes its payload bytes
//   (one byte written per cycle from the payload shifter), then the check runs
// completed pdu: each byte goes through ST_READ then ST_RDWAIT (registered ram read)
// input: the next request is taken once the final result is registered
// reset: state, fill count and output valid clear, registers take 0x03 / 0xFF;
//   the pdu ram is not cleared (only bytes below the fill count are read)

module hid_report_pdu_reassembler_top #(
	parameter int PDU_BYTES = hpr_pkg::PDU_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// report_tag, size_byte, payload_0 .. payload_5
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hpr_pkg::IN_DATA_W-1:0]     s_tdata,
	// status, ack_seen, pdu_byte, byte_index, zero pad
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hpr_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hpr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                        cfg_data
);
	import hpr_pkg::*;

	localparam int AW = $clog2(PDU_BYTES);
	localparam int FW = $clog2(PDU_BYTES + 1);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_WRITE  = 6'b000010,
		ST_CHECK  = 6'b000100,
		ST_RESULT = 6'b001000,
		ST_READ   = 6'b010000,
		ST_RDWAIT = 6'b100000
	} state_t;

	state_t        st_q;
	logic [7:0]    tag_q;
	logic [7:0]    start_q;
	logic [FW-1:0] fill_q;
	logic [2:0]    cnt_q;
	logic [AW-1:0] rd_idx_q;
	logic [7:0]    byte0_q;
	logic [7:0]    byte1_q;
	logic          ack_q;
	status_t       stat_q;

	// configuration, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q   <= TAG_RESET;
			start_q <= START_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TAG:   tag_q   <= cfg_data;
				REG_START: start_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request decode
	logic          s_acc;
	logic          tag_ok;
	logic          ack_in;
	logic [7:0]    size_eff;
	logic [FW-1:0] fill_eff;
	logic          overrun;

	assign s_tready = (st_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign tag_ok   = (s_tdata[7:0] == tag_q);
	assign ack_in   = tag_ok && s_tdata[15];
	assign size_eff = ack_in ? (s_tdata[15:8] & SIZE_MASK) : s_tdata[15:8];
	assign fill_eff = ack_in ? '0 : fill_q;
	assign overrun  = ((FW+1)'(fill_eff) + (FW+1)'(size_eff[2:0])) > (FW+1)'(PDU_BYTES);

	// payload digit shifter
	logic [7:0] digit;

	hpr_shift u_shift (
		.clk     (clk),
		.load    (s_acc),
		.shift   (st_q == ST_WRITE),
		.payload (s_tdata[IN_DATA_W-1:16]),
		.digit   (digit)
	);

	// pdu store
	logic [7:0] rd_data;

	hpr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (PDU_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (st_q == ST_WRITE),
		.waddr (fill_q[AW-1:0]),
		.wdata (digit),
		.raddr (rd_idx_q),
		.rdata (rd_data)
	);

	// result selection and output stage
	logic    out_free;
	logic    res_load;
	logic    last_b;
	logic [8:0] need;
	res_t    res;

	assign last_b   = (FW'(rd_idx_q) + FW'(1)) == fill_q;
	assign need     = {1'b0, byte1_q} + 9'd2;
	assign res_load = out_free && (st_q == ST_RESULT || st_q == ST_RDWAIT);

	always_comb begin
		if (st_q == ST_RDWAIT) begin
			res = '{status: STAT_COMPLETE, ack_seen: ack_q, pdu_byte: rd_data,
				byte_index: IDX_W'(rd_idx_q), last: last_b};
		end else begin
			res = '{status: stat_q, ack_seen: ack_q, pdu_byte: '0,
				byte_index: '0, last: 1'b1};
		end
	end

	hpr_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_load),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			fill_q   <= '0;
			cnt_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (!tag_ok) begin
							fill_q <= '0;
							st_q   <= ST_RESULT;
						end else if (size_eff > MAX_SIZE || overrun) begin
							fill_q <= '0;
							st_q   <= ST_RESULT;
						end else if (size_eff == 8'd0) begin
							fill_q <= fill_eff;
							st_q   <= ST_RESULT;
						end else begin
							fill_q <= fill_eff;
							cnt_q  <= size_eff[2:0];
							st_q   <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					// one payload byte into the store per cycle
					fill_q <= fill_q + FW'(1);
					cnt_q  <= cnt_q - 3'd1;
					if (cnt_q == 3'd1) begin
						st_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					rd_idx_q <= '0;
					if (byte0_q != start_q) begin
						fill_q <= '0;
						st_q   <= ST_RESULT;
					end else if (fill_q < FW'(2)) begin
						st_q <= ST_RESULT;
					end else if (9'(fill_q) < need) begin
						st_q <= ST_RESULT;
					end else if (9'(fill_q) > need) begin
						fill_q <= '0;
						st_q   <= ST_RESULT;
					end else begin
						st_q <= ST_READ;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					// ram read issued, data valid next cycle
					st_q <= ST_RDWAIT;
				end
				ST_RDWAIT: begin
					if (out_free) begin
						if (last_b) begin
							fill_q <= '0;
							st_q   <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q + AW'(1);
							st_q     <= ST_READ;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// per report status, ack mark and the two header bytes
	always_ff @(posedge clk) begin
		if (s_acc) begin
			ack_q <= ack_in;
			if (!tag_ok) begin
				stat_q <= STAT_BAD_TAG;
			end else if (size_eff > MAX_SIZE || overrun) begin
				stat_q <= STAT_BAD_PDU;
			end else begin
				stat_q <= STAT_PENDING;
			end
		end else if (st_q == ST_CHECK) begin
			if (byte0_q != start_q || (fill_q >= FW'(2) && 9'(fill_q) > need)) begin
				stat_q <= STAT_BAD_PDU;
			end else begin
				stat_q <= STAT_PENDING;
			end
		end
		if (st_q == ST_WRITE && fill_q == FW'(0)) begin
			byte0_q <= digit;
		end
		if (st_q == ST_WRITE && fill_q == FW'(1)) begin
			byte1_q <= digit;
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(PDU_BYTES))
		else $error("fill count beyond pdu store");

	a_write_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_WRITE |-> cnt_q != 3'd0)
		else $error("write phase with no bytes left");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!m_tvalid || m_tready))
		else $error("result loaded over a waiting result");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RDWAIT && res_load && last_b) |=> fill_q == '0)
		else $error("store not cleared after completed pdu");

endmodule

// ----- design/hpr_ram.sv -----
// hpr_ram: generic single write port, single read port ram with registered read
// no dependencies

module hpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/hpr_shift.sv -----
// hpr_shift: payload shift register, hands out one payload byte per cycle while shift is high
// depends on hpr_pkg

module hpr_shift (
	input  logic                                               clk,
	input  logic                                               load,
	input  logic                                               shift,
	input  logic [hpr_pkg::REPORT_PAYLOAD*hpr_pkg::BYTE_W-1:0] payload,
	output logic [hpr_pkg::BYTE_W-1:0]                         digit
);
	import hpr_pkg::*;

	localparam int SH_W = REPORT_PAYLOAD * BYTE_W;

	logic [SH_W-1:0] sh_q;

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q <= payload;
		end else if (shift) begin
			sh_q <= {{BYTE_W{1'b0}}, sh_q[SH_W-1:BYTE_W]};
		end
	end

	assign digit = sh_q[BYTE_W-1:0];

endmodule

// ----- design/hpr_out.sv -----
// hpr_out: output register stage of the result stream
// depends on hpr_pkg

module hpr_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  hpr_pkg::res_t                      res,
	output logic                               free,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [hpr_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                               m_tlast
);
	import hpr_pkg::*;

	logic valid_q;
	res_t res_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tlast  = res_q.last;
	assign m_tdata  = {7'd0, res_q.byte_index, res_q.pdu_byte, res_q.ack_seen, res_q.status};

endmodule

// ----- test/tb_hid_report_pdu_reassembler_top.sv -----
// tb_hid_report_pdu_reassembler_top: self-checking bench for the hid report pdu reassembler
// depends on hpr_pkg and hid_report_pdu_reassembler_top; stimulus is a directed table
// followed by random report runs, every result is checked against a local predictor or a typed-in value
`timescale 1ns / 100ps

module tb_hid_report_pdu_reassembler_top;
	import hpr_pkg::*;

	localparam int PDU_BYTES      = PDU_BYTES_DEF;
	localparam int RESET_CYCLES   = 9;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_OFF_LEN   = 400;
	localparam int PHASE_REPORTS  = 40;
	localparam int NUM_PHASES     = 6;

	// register index with no register behind it, writes must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

	// one input report, packed so that report_tag lands in the lowest byte of s_tdata
	typedef struct packed {
		logic [5:0][7:0] payload;
		logic [7:0]      size;
		logic [7:0]      tag;
	} report_t;

	// one output result as the predictor sees it
	typedef struct packed {
		status_t    status;
		logic       ack;
		logic [7:0] data;
		logic [5:0] pos;
		logic       last;
	} pdu_result_t;

	// directed table row, with a typed-in single result where one is obvious
	typedef struct packed {
		report_t rep;
		logic    typed;
		status_t st;
		logic    ack;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [7:0]             cfg_data;

	hid_report_pdu_reassembler_top #(
		.PDU_BYTES(PDU_BYTES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state: its own copy of the registers and the pdu buffer
	logic [7:0]  tag_cfg;
	logic [7:0]  start_cfg;
	logic [7:0]  pdu_mem [PDU_BYTES];
	int          pdu_fill;

	pdu_result_t fresh_results[$];     // results caused by the report just accepted
	pdu_result_t awaited_results[$];   // results still owed by the block, oldest first
	dir_row_t    directed_rows[$];

	// idling knobs: idle and stall in percent of cycles, hold-off length and countdown
	int          idle_pct;
	int          stall_pct;
	int          hold_len;
	int          hold_left;

	int          errors;
	int          reports_sent;
	int          results_seen;
	int          pdus_completed;
	int          quiet_cycles;

	function automatic pdu_result_t make_result(status_t st, logic ack, logic [7:0] data,
			logic [5:0] pos, logic last);
		pdu_result_t res;
		res.status = st;
		res.ack    = ack;
		res.data   = data;
		res.pos    = pos;
		res.last   = last;
		return res;
	endfunction

	// mirrors the reassembly rules for one accepted report, fills fresh_results
	function automatic void predict_report(report_t r);
		logic [7:0] sz;
		logic       ack;
		int         need;
		int         k;
		fresh_results.delete();
		if (r.tag != tag_cfg) begin
			// tag mismatch: buffer dropped, ack never reported
			pdu_fill = 0;
			fresh_results.push_back(make_result(STAT_BAD_TAG, 1'b0, 8'h00, 6'd0, 1'b1));
			return;
		end
		sz  = r.size;
		ack = 1'b0;
		if (sz[7]) begin
			// acknowledge: fresh buffer, size taken from the low six bits
			ack      = 1'b1;
			pdu_fill = 0;
			sz       = sz & SIZE_MASK;
		end
		if (sz > MAX_SIZE || pdu_fill + int'(sz) > PDU_BYTES) begin
			pdu_fill = 0;
			fresh_results.push_back(make_result(STAT_BAD_PDU, ack, 8'h00, 6'd0, 1'b1));
			return;
		end
		if (sz == 8'd0) begin
			fresh_results.push_back(make_result(STAT_PENDING, ack, 8'h00, 6'd0, 1'b1));
			return;
		end
		for (k = 0; k < int'(sz); k++)
			pdu_mem[pdu_fill + k] = r.payload[k];
		pdu_fill += int'(sz);
		if (pdu_mem[0] != start_cfg) begin
			pdu_fill = 0;
			fresh_results.push_back(make_result(STAT_BAD_PDU, ack, 8'h00, 6'd0, 1'b1));
			return;
		end
		// one byte held: only the start byte can be judged
		if (pdu_fill < 2) begin
			fresh_results.push_back(make_result(STAT_PENDING, ack, 8'h00, 6'd0, 1'b1));
			return;
		end
		need = int'(pdu_mem[1]) + 2;
		if (pdu_fill < need) begin
			fresh_results.push_back(make_result(STAT_PENDING, ack, 8'h00, 6'd0, 1'b1));
			return;
		end
		if (pdu_fill > need) begin
			pdu_fill = 0;
			fresh_results.push_back(make_result(STAT_BAD_PDU, ack, 8'h00, 6'd0, 1'b1));
			return;
		end
		// complete: whole pdu read out, one byte per result
		for (k = 0; k < pdu_fill; k++)
			fresh_results.push_back(make_result(STAT_COMPLETE, ack, pdu_mem[k], 6'(k),
				k + 1 == pdu_fill));
		pdu_fill = 0;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch: %s got %0d want %0d (report %0d, t=%0t)", what, got, want,
			reports_sent, $realtime);
	endtask

	function automatic void add_row(logic [7:0] tag, logic [7:0] size, logic [47:0] pl,
			logic typed, status_t st, logic ack);
		dir_row_t row;
		row.rep.tag     = tag;
		row.rep.size    = size;
		row.rep.payload = pl;
		row.typed       = typed;
		row.st          = st;
		row.ack         = ack;
		directed_rows.push_back(row);
	endfunction

	// offer one report, wait for the request to be taken, then book what it owes
	task automatic drive_report(report_t r, logic typed, status_t st, logic ack_want);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= r;
		do
			@(posedge clk);
		while (!s_tready);
		reports_sent++;
		predict_report(r);
		if (typed)
			awaited_results.push_back(make_result(st, ack_want, 8'h00, 6'd0, 1'b1));
		else
			foreach (fresh_results[i])
				awaited_results.push_back(fresh_results[i]);
	endtask

	// register writes back to back, cfg_valid lowered once at the end
	task automatic apply_settings(logic [7:0] tag, logic [7:0] start, logic with_spare);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [7:0]           val [3];
		int                   first;
		int                   k;
		idx[0] = REG_SPARE;
		val[0] = 8'h5C;
		idx[1] = REG_TAG;
		val[1] = tag;
		idx[2] = REG_START;
		val[2] = start;
		first  = with_spare ? 0 : 1;
		for (k = first; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= val[k];
			do
				@(posedge clk);
			while (!cfg_ready);
			case (idx[k])
				REG_TAG:   tag_cfg = val[k];
				REG_START: start_cfg = val[k];
				default:   ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// stop offering, let every owed result come out, then let the block go quiet
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// a well-formed pdu split into reports of random size, sometimes with a flaw
	task automatic send_pdu_run();
		logic [7:0] run_bytes [$];
		report_t    r;
		report_t    blank;
		int         pick;
		int         len_byte;
		int         total;
		int         sent;
		int         chunk;
		int         flaw;
		int         bad_at;
		int         k;
		logic       ack_first;
		pick = $urandom_range(99);
		// mostly short pdus, some long ones, a few whose length cannot fit the buffer
		if (pick < 60)
			len_byte = $urandom_range(0, 12);
		else if (pick < 88)
			len_byte = $urandom_range(13, 46);
		else
			len_byte = $urandom_range(47, 60);
		total = len_byte + 2;
		if (total > PDU_BYTES + 6)
			total = PDU_BYTES + 6;
		run_bytes.push_back(start_cfg);
		run_bytes.push_back(8'(len_byte));
		for (k = 2; k < total; k++)
			run_bytes.push_back(8'($urandom_range(255)));
		// flaws: wrong tag mid-run, one byte too many, bad start byte, empty report inside
		flaw = $urandom_range(0, 11);
		if (flaw == 1) begin
			run_bytes.push_back(8'($urandom_range(255)));
			total++;
		end
		if (flaw == 2)
			run_bytes[0] = run_bytes[0] ^ (8'h01 << $urandom_range(7));
		bad_at    = $urandom_range(0, total - 1);
		ack_first = $urandom_range(99) < 70;
		sent      = 0;
		while (sent < total) begin
			chunk = $urandom_range(1, 6);
			if (chunk > total - sent)
				chunk = total - sent;
			r.tag  = tag_cfg;
			r.size = 8'(chunk);
			for (k = 0; k < 6; k++)
				r.payload[k] = (k < chunk) ? run_bytes[sent + k] : 8'($urandom_range(255));
			if (sent == 0 && ack_first) begin
				// bit 6 rides along to exercise the size mask
				r.size[7] = 1'b1;
				r.size[6] = 1'($urandom_range(1));
			end
			if (bad_at >= sent && bad_at < sent + chunk) begin
				if (flaw == 0)
					r.tag = tag_cfg ^ (8'h01 << $urandom_range(7));
				if (flaw == 3) begin
					blank.tag  = tag_cfg;
					blank.size = 8'h00;
					for (k = 0; k < 6; k++)
						blank.payload[k] = 8'($urandom_range(255));
					drive_report(blank, 1'b0, STAT_PENDING, 1'b0);
				end
			end
			drive_report(r, 1'b0, STAT_PENDING, 1'b0);
			sent += chunk;
		end
	endtask

	// loose report: random tag half of the time, sizes biased toward the legal range
	task automatic send_noise();
		report_t r;
		int      k;
		r.tag  = $urandom_range(1) ? tag_cfg : 8'($urandom_range(255));
		r.size = 8'($urandom_range(255));
		if ($urandom_range(1))
			r.size = r.size & 8'hC7;
		for (k = 0; k < 6; k++)
			r.payload[k] = 8'($urandom_range(255));
		drive_report(r, 1'b0, STAT_PENDING, 1'b0);
	endtask

	// receiver: random stalls, or a long hold-off counted here once requested
	always @(posedge clk) begin
		if (hold_len > 0) begin
			hold_left = hold_len;
			hold_len  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// result checker: m_tdata holds status, ack_seen, pdu_byte, byte_index from bit 0 up
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				flag_mismatch("result with nothing awaited, tdata", int'(m_tdata), 0);
			end else begin
				if (m_tdata[1:0] !== awaited_results[0].status)
					flag_mismatch("status", int'(m_tdata[1:0]), int'(awaited_results[0].status));
				if (m_tdata[2] !== awaited_results[0].ack)
					flag_mismatch("ack_seen", int'(m_tdata[2]), int'(awaited_results[0].ack));
				if (m_tdata[10:3] !== awaited_results[0].data)
					flag_mismatch("pdu_byte", int'(m_tdata[10:3]), int'(awaited_results[0].data));
				if (m_tdata[16:11] !== awaited_results[0].pos)
					flag_mismatch("byte_index", int'(m_tdata[16:11]), int'(awaited_results[0].pos));
				if (m_tlast !== awaited_results[0].last)
					flag_mismatch("last", int'(m_tlast), int'(awaited_results[0].last));
				if (awaited_results[0].status == STAT_COMPLETE && awaited_results[0].last)
					pdus_completed++;
				void'(awaited_results.pop_front());
			end
		end
	end

	// watchdog: any request on any channel restarts the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles, %0d results still awaited",
				quiet_cycles, awaited_results.size());
			$display("hid_report_pdu_reassembler_top regression: fail");
			$finish;
		end
	end

	initial begin
		int       phase;
		int       target;
		logic [7:0] phase_tag;
		logic [7:0] phase_start;

		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_TAG;
		cfg_data       = 8'h00;
		idle_pct       = 0;
		stall_pct      = 0;
		hold_len       = 0;
		hold_left      = 0;
		errors         = 0;
		reports_sent   = 0;
		results_seen   = 0;
		pdus_completed = 0;
		quiet_cycles   = 0;
		// predictor starts from the reset values of the registers
		tag_cfg        = TAG_RESET;
		start_cfg      = START_RESET;
		pdu_fill       = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, run on the reset register values (tag 0x03, start 0xff)
		// payload is written payload_5 .. payload_0, payload_0 in the low byte
		add_row(8'h00, 8'h02, 48'hFFFFFFFFFFFF, 1'b1, STAT_BAD_TAG, 1'b0);  // tag low extreme
		add_row(8'hFF, 8'h86, 48'h000000000000, 1'b1, STAT_BAD_TAG, 1'b0);  // ack hidden by bad tag
		add_row(8'h03, 8'h00, 48'hFFFFFFFFFFFF, 1'b1, STAT_PENDING, 1'b0);  // size zero
		add_row(8'h03, 8'h80, 48'hFFFFFFFFFFFF, 1'b1, STAT_PENDING, 1'b1);  // bare acknowledge
		add_row(8'h03, 8'h07, 48'h0102FF0102FF, 1'b1, STAT_BAD_PDU, 1'b0);  // size above six
		add_row(8'h03, 8'hFF, 48'h0102030405FF, 1'b1, STAT_BAD_PDU, 1'b1);  // masked size 63
		add_row(8'h03, 8'h86, 48'h000000000000, 1'b1, STAT_BAD_PDU, 1'b1);  // wrong start byte
		add_row(8'h03, 8'h01, 48'h5A5A5A5A5AFF, 1'b1, STAT_PENDING, 1'b0);  // single byte held
		add_row(8'h03, 8'h01, 48'hA5A5A5A5A500, 1'b0, STAT_PENDING, 1'b0);  // shortest pdu
		add_row(8'h03, 8'h06, 48'h4433221104FF, 1'b0, STAT_PENDING, 1'b0);  // pdu in one report
		add_row(8'h03, 8'h06, 48'h0000000001FF, 1'b1, STAT_BAD_PDU, 1'b0);  // fill past length
		add_row(8'h03, 8'h40, 48'h0102030405FF, 1'b1, STAT_BAD_PDU, 1'b0);  // bit 6, no ack
		// longest pdu: length byte 46 fills all 48 buffer bytes
		add_row(8'h03, 8'hC6, 48'h040302012EFF, 1'b0, STAT_PENDING, 1'b0);
		add_row(8'h03, 8'h06, 48'hFFEEDDCCBBAA, 1'b0, STAT_PENDING, 1'b0);
		add_row(8'h03, 8'h06, 48'h000000000000, 1'b0, STAT_PENDING, 1'b0);
		add_row(8'h03, 8'h06, 48'hFFFFFFFFFFFF, 1'b0, STAT_PENDING, 1'b0);
		add_row(8'h03, 8'h06, 48'h55AA55AA55AA, 1'b0, STAT_PENDING, 1'b0);
		add_row(8'h03, 8'h06, 48'h0F1E2D3C4B5A, 1'b0, STAT_PENDING, 1'b0);
		add_row(8'h03, 8'h06, 48'h807F01FE10EF, 1'b0, STAT_PENDING, 1'b0);
		add_row(8'h03, 8'h06, 48'h123456789ABC, 1'b0, STAT_PENDING, 1'b0);
		add_row(8'h03, 8'hC0, 48'hFFFFFFFFFFFF, 1'b1, STAT_PENDING, 1'b1);  // ack with bit 6 only
		foreach (directed_rows[i])
			drive_report(directed_rows[i].rep, directed_rows[i].typed, directed_rows[i].st,
				directed_rows[i].ack);

		// random part, one register setting and one idling mix per phase
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			settle_block();
			case (phase)
				0: begin
					phase_tag   = 8'h00;
					phase_start = 8'h00;
					idle_pct    = 0;
					stall_pct   = 0;
				end
				1: begin
					phase_tag   = 8'hFF;
					phase_start = 8'hFF;
					idle_pct    = 60;
					stall_pct   = 0;
				end
				2: begin
					phase_tag   = 8'hA5;
					phase_start = 8'h5A;
					idle_pct    = 0;
					stall_pct   = 60;
				end
				3: begin
					phase_tag   = 8'($urandom_range(255));
					phase_start = 8'($urandom_range(255));
					idle_pct    = 34;
					stall_pct   = 34;
				end
				4: begin
					phase_tag   = 8'($urandom_range(255));
					phase_start = 8'($urandom_range(255));
					idle_pct    = 0;
					stall_pct   = 0;
				end
				default: begin
					phase_tag   = TAG_RESET;
					phase_start = START_RESET;
					idle_pct    = 34;
					stall_pct   = 34;
				end
			endcase
			// the spare index is written once, the block must leave both registers alone
			apply_settings(phase_tag, phase_start, phase == 2);
			// long output hold-off while reports keep coming, so the input backs up
			if (phase == 4)
				hold_len = HOLD_OFF_LEN;
			target = reports_sent + PHASE_REPORTS;
			while (reports_sent < target) begin
				if ($urandom_range(99) < 75)
					send_pdu_run();
				else
					send_noise();
			end
		end
		settle_block();

		$display("covered %0d reports, %0d results, %0d completed pdus, %0d register settings",
			reports_sent, results_seen, pdus_completed, NUM_PHASES + 1);
		$display("idle and stall mixes, one long output hold-off, %0d mismatches", errors);
		if (errors == 0)
			$display("hid_report_pdu_reassembler_top regression: pass");
		else
			$display("hid_report_pdu_reassembler_top regression: fail");
		$finish;
	end

endmodule
